>>> rtl/lfr_pkg.sv
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared types, codes and helpers of the LIN frame receiver.
// ----------------------------------------------------------------------------
package lfr_pkg;

   localparam int RESPONSE_BYTES = 8;
   localparam int FRAME_BUF      = 8;

   localparam logic [3:0] HEADER_LEN = 4'd4;
   localparam logic [3:0] RESP_LEN   = 4'(RESPONSE_BYTES + 1);
   localparam logic [3:0] GUARD_LEN  = 4'd13;
   localparam logic [3:0] MIN_RESP   = 4'd2;
   localparam logic [3:0] RESP_CRC_BYTES = 4'(RESPONSE_BYTES);

   localparam logic [7:0] CRC_POLY = 8'h8C;

   localparam logic [7:0]  DEVICE_ID_RESET = 8'hCA;
   localparam logic [15:0] TIMEOUT_RESET   = 16'd100;

   localparam logic CSR_DEVICE_ID = 1'b0;
   localparam logic CSR_TIMEOUT   = 1'b1;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [2:0] ST_NONE      = 3'd0;
   localparam logic [2:0] ST_HDR_US    = 3'd1;
   localparam logic [2:0] ST_HDR_OTHER = 3'd2;
   localparam logic [2:0] ST_RESP_OK   = 3'd3;
   localparam logic [2:0] ST_CRC_BAD   = 3'd4;
   localparam logic [2:0] ST_TIMEOUT   = 3'd5;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  frame_id;
      logic [63:0] response_data;
   } rsp_type;

   // reflected CRC-8, one byte, LSB first
   function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic [7:0] d;
      c = crc;
      d = b;
      for (int k = 0; k < 8; k++) begin
         if (c[0] ^ d[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
         d = d >> 1;
      end
      return c;
   endfunction

endpackage

>>> rtl/lfr_frame_engine.sv
// ----------------------------------------------------------------------------
// lfr_frame_engine
// Frame state, CRC, idle counter and configuration registers; computes the
// result of one request combinationally and commits state on step.
// ----------------------------------------------------------------------------
module lfr_frame_engine import lfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        command,
   input  logic [7:0]  data_byte,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   output rsp_type     result
);

   logic [7:0]  device_id_ff, device_id_in;
   logic [15:0] timeout_ff, timeout_in;
   logic [3:0]  count_ff, count_in;
   logic [7:0]  crc_ff, crc_in;
   logic [15:0] idle_ff, idle_in;
   logic [7:0]  last_id_ff, last_id_in;
   logic [7:0]  frame_ff [FRAME_BUF];
   logic [7:0]  frame_in [FRAME_BUF];

   logic [7:0]  bytes_new [FRAME_BUF];
   logic [7:0]  crc_step;
   logic [3:0]  count_inc;
   logic [15:0] idle_inc;
   logic        zero_start;
   logic [2:0]  status;
   logic [63:0] data;

   always_comb begin
      device_id_in = device_id_ff;
      timeout_in   = timeout_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DEVICE_ID: device_id_in = csr_wdata[7:0];
            CSR_TIMEOUT:   timeout_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int k = 0; k < FRAME_BUF; k++) begin
         bytes_new[k] = (count_ff == 4'(k)) ? data_byte : frame_ff[k];
      end
      crc_step   = (count_ff < RESP_CRC_BYTES) ? crc_update(crc_ff, data_byte) : crc_ff;
      count_inc  = count_ff + 4'd1;
      idle_inc   = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
      zero_start = (bytes_new[0] == 8'd0) && (bytes_new[1] == 8'd0);

      count_in   = count_ff;
      crc_in     = crc_ff;
      idle_in    = idle_ff;
      last_id_in = last_id_ff;
      frame_in   = frame_ff;
      status     = ST_NONE;
      data       = '0;

      if (command == CMD_TICK) begin
         idle_in = idle_inc;
         if (count_ff != 4'd0 && idle_inc > timeout_ff) begin
            count_in = '0;
            crc_in   = '0;
            status   = ST_TIMEOUT;
         end
      end else begin
         frame_in = bytes_new;
         crc_in   = crc_step;
         count_in = count_inc;
         idle_in  = '0;
         if (count_inc == HEADER_LEN && zero_start) begin
            last_id_in = bytes_new[3];
            status     = (bytes_new[3] == device_id_ff) ? ST_HDR_US : ST_HDR_OTHER;
            count_in   = '0;
            crc_in     = '0;
         end else if (!zero_start && count_inc >= MIN_RESP && count_inc == RESP_LEN) begin
            if (data_byte == crc_step) begin
               status = ST_RESP_OK;
               for (int k = 0; k < RESPONSE_BYTES; k++) begin
                  data[8*k +: 8] = bytes_new[k];
               end
            end else begin
               status = ST_CRC_BAD;
            end
            count_in = '0;
            crc_in   = '0;
         end else if (count_inc >= GUARD_LEN) begin
            count_in = '0;
            crc_in   = '0;
         end
      end
   end

   assign result.status        = status;
   assign result.frame_id      = last_id_in;
   assign result.response_data = data;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff <= DEVICE_ID_RESET;
         timeout_ff   <= TIMEOUT_RESET;
         count_ff     <= '0;
         crc_ff       <= '0;
         idle_ff      <= '0;
         last_id_ff   <= '0;
         for (int k = 0; k < FRAME_BUF; k++) begin
            frame_ff[k] <= '0;
         end
      end else begin
         device_id_ff <= device_id_in;
         timeout_ff   <= timeout_in;
         if (step) begin
            count_ff   <= count_in;
            crc_ff     <= crc_in;
            idle_ff    <= idle_in;
            last_id_ff <= last_id_in;
            frame_ff   <= frame_in;
         end
      end
   end

endmodule

>>> rtl/lin_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// lin_frame_receiver_core
// LIN slave frame receiver: header decode, response CRC check, idle timeout.
// ----------------------------------------------------------------------------
// A response appears in the cycle after its request is accepted.
// Throughput: 1 request per cycle; req_ready drops only while a response
// waits and rsp_ready is low (single output register).
// Reset (synchronous): frame state, counters and last id cleared,
// device_id = 0xCA, timeout_ticks = 100, no response pending.
module lin_frame_receiver_core import lfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_frame_id,
   output logic [63:0] rsp_response_data,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic    accept;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type result;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   lfr_frame_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .command   (req_command),
      .data_byte (req_data_byte),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .result    (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_frame_id      = rsp_ff.frame_id;
   assign rsp_response_data = rsp_ff.response_data;

`ifndef SYNTHESIS
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_accept_valid: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request without response");

   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_RESP_OK |-> rsp_response_data == 64'd0)
      else $error("response data set on non-ok status");

   a_tick_status: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == CMD_TICK
      |=> rsp_status == ST_NONE || rsp_status == ST_TIMEOUT)
      else $error("tick produced a frame status");
`endif

endmodule
